// ===== design/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg: shared types and constants for the formal concept test block
// Holds the word layouts, the command and register codes, the token that
// walks the cell chain and the low-mask helper.
// ----------------------------------------------------------------------------
package fct_pkg;

   localparam int LEFT_MAX    = 16;
   localparam int RIGHT_MAX   = 16;
   localparam int ROW_IDX_W   = $clog2(LEFT_MAX);
   localparam int COUNT_W     = 5;
   localparam int CSR_INDEX_W = 2;

   // commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_COUNT = 2'd1;

   typedef struct packed {
      logic                 command;
      logic [ROW_IDX_W-1:0] row_index;
      logic [RIGHT_MAX-1:0] row_bits;
      logic [LEFT_MAX-1:0]  left_set;
   } req_type;

   typedef struct packed {
      logic [RIGHT_MAX-1:0] right_set;
      logic                 is_concept;
   } rsp_type;

   // check = 0: closure pass, acc narrows; check = 1: maximality pass
   typedef struct packed {
      logic                 valid;
      logic                 check;
      logic [RIGHT_MAX-1:0] acc;
      logic                 maximal;
   } token_type;

   // ones in the low n bits, all ones when n covers the whole word
   function automatic logic [RIGHT_MAX-1:0] low_mask(input logic [COUNT_W-1:0] n);
      logic [RIGHT_MAX-1:0] m;
      if (n >= COUNT_W'(RIGHT_MAX)) begin
         m = '1;
      end else begin
         m = (RIGHT_MAX'(1) << n) - RIGHT_MAX'(1);
      end
      return m;
   endfunction

endpackage

// ===== design/fct_cell.sv =====
// ----------------------------------------------------------------------------
// fct_cell: one left vertex of the chain
// Stores the neighbour row of its vertex and applies it to the token that
// passes through, one cell per cycle.
// ----------------------------------------------------------------------------
module fct_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  fct_pkg::token_type               tok_i,
   output fct_pkg::token_type               tok_o,
   input  logic                             wr_en,
   input  logic [fct_pkg::RIGHT_MAX-1:0]    wr_row,
   input  logic                             chosen,
   input  logic                             in_use
);
   import fct_pkg::*;

   logic [RIGHT_MAX-1:0] row_ff, row_in;
   token_type            tok_ff, tok_in;
   logic                 hit;

   assign row_in = wr_en ? wr_row : row_ff;
   assign hit    = ((row_ff & tok_i.acc) == tok_i.acc);

   always_comb begin
      tok_in = tok_i;
      if (!tok_i.check) begin
         if (chosen) begin
            tok_in.acc = tok_i.acc & row_ff;
         end
      end else if (in_use && !chosen && hit) begin
         // an unchosen vertex covers the closure: set is not maximal
         tok_in.maximal = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

// ===== design/formal_concept_test_top.sv =====
// ----------------------------------------------------------------------------
// formal_concept_test_top: closure and maximality test over neighbour rows
// A chain of cells, one per left vertex, holds the neighbour rows and walks
// a token through them to form the closure and the concept flag.
// ----------------------------------------------------------------------------
// A load word is taken and the block is ready again right away.
// A test word runs from accept to response in steps: a launch state, the
// closure token crossing the 16-cell chain, the maximality token crossing
// it again, and a move of the result into the output register. The block
// takes the next word once the result sits in that register; if the
// previous response is still waiting there, the finished result is held
// until it drains. Configuration writes are taken in every cycle.
module formal_concept_test_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  fct_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output fct_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fct_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fct_pkg::COUNT_W-1:0]    csr_wdata
);
   import fct_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LAUNCH = 3'd1;
   localparam logic [2:0] ST_CLOSE  = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [LEFT_MAX-1:0]  chosen_ff, chosen_in;
   logic [RIGHT_MAX-1:0] closure_ff, closure_in;
   logic                 maximal_ff, maximal_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]   left_count_ff, left_count_in;
   logic [COUNT_W-1:0]   right_count_ff, right_count_in;

   logic [LEFT_MAX-1:0]  use_mask;
   logic [RIGHT_MAX-1:0] row_mask;
   logic                 req_fire, load_fire, test_fire;
   token_type            tok [0:LEFT_MAX];
   token_type            launch_tok;
   token_type            chain_out;

   assign use_mask  = LEFT_MAX'(low_mask(left_count_ff));
   assign row_mask  = low_mask(right_count_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign load_fire = req_fire && (req_data.command == CMD_LOAD);
   assign test_fire = req_fire && (req_data.command == CMD_TEST);

   assign chain_out = tok[LEFT_MAX];

   // ---- cell chain --------------------------------------------------------
   for (genvar i = 0; i < LEFT_MAX; i++) begin : g_cell
      fct_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_i  (tok[i]),
         .tok_o  (tok[i+1]),
         .wr_en  (load_fire && (req_data.row_index == ROW_IDX_W'(i))),
         .wr_row (req_data.row_bits & row_mask),
         .chosen (chosen_ff[i]),
         .in_use (use_mask[i])
      );
   end

   // ---- token launch ------------------------------------------------------
   always_comb begin
      launch_tok         = '0;
      launch_tok.acc     = '1;
      launch_tok.maximal = 1'b1;
      if (state_ff == ST_LAUNCH) begin
         launch_tok.valid = 1'b1;
      end else if (state_ff == ST_CLOSE && chain_out.valid) begin
         // turn the closure around for the maximality pass
         launch_tok.valid = 1'b1;
         launch_tok.check = 1'b1;
         launch_tok.acc   = chain_out.acc;
      end
   end

   assign tok[0] = launch_tok;

   // ---- sequencer ---------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      chosen_in    = chosen_ff;
      closure_in   = closure_ff;
      maximal_in   = maximal_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (test_fire) begin
               chosen_in = req_data.left_set & use_mask;
               state_in  = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            if (chain_out.valid) begin
               closure_in = (chosen_ff != '0) ? chain_out.acc : '0;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (chain_out.valid) begin
               maximal_in = chain_out.maximal;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.right_set  = closure_ff;
               rsp_data_in.is_concept = (closure_ff != '0) && maximal_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---- configuration -----------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LEFT_COUNT:  left_count_in  = csr_wdata;
            CSR_RIGHT_COUNT: right_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         left_count_ff  <= COUNT_W'(LEFT_MAX);
         right_count_ff <= COUNT_W'(RIGHT_MAX);
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
      end
   end

   always_ff @(posedge clock) begin
      chosen_ff   <= chosen_in;
      closure_ff  <= closure_in;
      maximal_ff  <= maximal_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/fct_checker.sv =====
// ----------------------------------------------------------------------------
// fct_checker: port-level checks for the formal concept test block
// Watches the top level's ports and flags ordering and result slips.
// ----------------------------------------------------------------------------
module fct_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  fct_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  fct_pkg::rsp_type                rsp_data
);
   import fct_pkg::*;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // a load never blocks the next word
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command == CMD_LOAD |=> req_ready)
      else $error("ready dropped after a load");

   // a test occupies the block
   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command == CMD_TEST |=> !req_ready)
      else $error("ready stayed high after a test");

   // a new response only comes out of a running test
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared while idle");

   // a concept has a nonempty closure
   a_concept_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_concept |-> rsp_data.right_set != '0)
      else $error("concept flagged with empty closure");

endmodule

bind formal_concept_test_top fct_checker u_fct_checker (.*);
